FILE: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types, codes and the control program of the drum step sequencer.
// ----------------------------------------------------------------------------
package dss_pkg;

	// item operation codes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_TOGGLE = 2'd2;
	localparam logic [1:0] OP_READ   = 2'd3;

	// configuration register indexes
	localparam logic REG_TEMPO = 1'b0;
	localparam logic REG_RUN   = 1'b1;

	// tempo limits and reset value
	localparam logic [7:0] TEMPO_MIN   = 8'd40;
	localparam logic [7:0] TEMPO_MAX   = 8'd240;
	localparam logic [7:0] TEMPO_RESET = 8'd120;

	// 60 s / 4 steps per beat in microseconds times bpm
	localparam int unsigned UNITS_PER_STEP = 15000000;
	localparam int          SUM_W          = 25;
	localparam int          ACC_W          = 24;
	localparam int          TRIG_LIMIT     = 16;

	// program steps
	localparam int          STEP_W    = 4;
	localparam logic [3:0]  STP_IDLE   = 4'd0;
	localparam logic [3:0]  STP_DISP   = 4'd1;
	localparam logic [3:0]  STP_TICK   = 4'd2;
	localparam logic [3:0]  STP_MUL    = 4'd3;
	localparam logic [3:0]  STP_ADD    = 4'd4;
	localparam logic [3:0]  STP_CHK    = 4'd5;
	localparam logic [3:0]  STP_SCAN   = 4'd6;
	localparam logic [3:0]  STP_LOOP   = 4'd7;
	localparam logic [3:0]  STP_COMMIT = 4'd8;
	localparam logic [3:0]  STP_RST    = 4'd9;
	localparam logic [3:0]  STP_CLOSE  = 4'd10;
	localparam logic [3:0]  STP_CELL   = 4'd11;

	// datapath actions
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_MUL     = 3'd1;
	localparam logic [2:0] ACT_ADD     = 3'd2;
	localparam logic [2:0] ACT_ADVANCE = 3'd3;
	localparam logic [2:0] ACT_SCAN    = 3'd4;
	localparam logic [2:0] ACT_COMMIT  = 3'd5;
	localparam logic [2:0] ACT_CLEAR   = 3'd6;
	localparam logic [2:0] ACT_CELL    = 3'd7;

	// jump conditions
	localparam logic [2:0] CND_NEVER    = 3'd0;
	localparam logic [2:0] CND_ALWAYS   = 3'd1;
	localparam logic [2:0] CND_NOSTART  = 3'd2;
	localparam logic [2:0] CND_CELLOP   = 3'd3;
	localparam logic [2:0] CND_RESTART  = 3'd4;
	localparam logic [2:0] CND_STOPPED  = 3'd5;
	localparam logic [2:0] CND_SUMLOW   = 3'd6;
	localparam logic [2:0] CND_TRKMORE  = 3'd7;

	typedef struct packed {
		logic [2:0]        act;
		logic [2:0]        cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	// control store: one word per step
	function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
		ctrl_t w;
		w = '{act: ACT_NONE, cond: CND_ALWAYS, target: STP_IDLE};
		case (step)
			STP_IDLE:   w = '{act: ACT_NONE,    cond: CND_NOSTART, target: STP_IDLE};
			STP_DISP:   w = '{act: ACT_NONE,    cond: CND_CELLOP,  target: STP_CELL};
			STP_TICK:   w = '{act: ACT_NONE,    cond: CND_RESTART, target: STP_RST};
			STP_MUL:    w = '{act: ACT_MUL,     cond: CND_STOPPED, target: STP_CLOSE};
			STP_ADD:    w = '{act: ACT_ADD,     cond: CND_NEVER,   target: STP_IDLE};
			STP_CHK:    w = '{act: ACT_ADVANCE, cond: CND_SUMLOW,  target: STP_COMMIT};
			STP_SCAN:   w = '{act: ACT_SCAN,    cond: CND_TRKMORE, target: STP_SCAN};
			STP_LOOP:   w = '{act: ACT_NONE,    cond: CND_ALWAYS,  target: STP_CHK};
			STP_COMMIT: w = '{act: ACT_COMMIT,  cond: CND_ALWAYS,  target: STP_CLOSE};
			STP_RST:    w = '{act: ACT_CLEAR,   cond: CND_NEVER,   target: STP_IDLE};
			STP_CLOSE:  w = '{act: ACT_NONE,    cond: CND_ALWAYS,  target: STP_IDLE};
			STP_CELL:   w = '{act: ACT_CELL,    cond: CND_ALWAYS,  target: STP_CLOSE};
			default:    w = '{act: ACT_NONE,    cond: CND_ALWAYS,  target: STP_IDLE};
		endcase
		return w;
	endfunction

endpackage

FILE: rtl/drum_step_sequencer_unit.sv
// ----------------------------------------------------------------------------
// drum_step_sequencer_unit
// Step sequencer over a track-by-step on/off grid, run by a small microprogram.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; every item then yields
// zero or more trigger results and one closing result (last = 1), each shown
// for exactly one cycle with strobe high. The receiver cannot stall, so the
// block never waits on it. Items are handled one at a time, paced by the
// microprogram counter: a cell item runs the dispatch, cell and close steps;
// a restart tick runs dispatch, tick, clear and close; a stopped tick closes
// after the multiply; a running tick multiplies, adds, then for each of the k
// steps it passes (k is 0, 1 or 2) scans the grid row one track per cycle,
// then closes. busy falls in the cycle that shows the closing result, and a
// new item may be taken there. The grid resets to all cleared; no clearing
// pass is needed. Configuration is to be written only while the block is
// idle (not enforced by the block); tempo writes are clamped to 40..240.
// ----------------------------------------------------------------------------
module drum_step_sequencer_unit #(
	parameter int TRACK_COUNT = 8,
	parameter int STEP_COUNT  = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	// item in
	input  logic       start,
	output logic       busy,
	input  logic [1:0] op,
	input  logic       restart,
	input  logic [15:0] elapsed_us,
	input  logic [3:0] track_index,
	input  logic [4:0] step_index,
	input  logic       cell_enable,
	// results
	output logic       strobe,
	output logic       kind,
	output logic [3:0] fired_track,
	output logic [3:0] position,
	output logic       cell_value,
	output logic       last
);

	localparam int TRK_W = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
	localparam int POS_W = $clog2(STEP_COUNT);

	// control
	logic [dss_pkg::STEP_W-1:0] step_q;
	dss_pkg::ctrl_t             cw;
	logic                       jump;

	// registers
	logic [7:0]             tempo_q;
	logic                   run_q;

	// state
	logic [STEP_COUNT-1:0]  grid_q [TRACK_COUNT];
	logic [POS_W-1:0]       pos_q;
	logic [dss_pkg::ACC_W-1:0] acc_q;

	// working registers
	logic [1:0]             op_q;
	logic                   rst_q;
	logic [15:0]            us_q;
	logic [3:0]             t_q;
	logic [4:0]             s_q;
	logic                   en_q;
	logic [23:0]            prod_q;
	logic [dss_pkg::SUM_W-1:0] sum_q;
	logic [TRK_W-1:0]       trk_q;
	logic [4:0]             ntrig_q;
	logic                   readv_q;

	// datapath signals
	logic                   accept;
	logic                   in_range;
	logic                   is_tick;
	logic [TRK_W-1:0]       row_addr;
	logic [POS_W-1:0]       col_addr;
	logic [STEP_COUNT-1:0]  row;
	logic                   cell_bit;
	logic [TRK_W+3:0]       trk_ext;
	logic [POS_W+3:0]       pos_ext;

	assign busy   = (step_q != dss_pkg::STP_IDLE);
	assign accept = start && !busy;
	assign cw     = dss_pkg::ucode_rom(step_q);

	// cell index check against the grid size
	assign in_range = ({1'b0, t_q} < 5'(TRACK_COUNT)) && ({1'b0, s_q} < 6'(STEP_COUNT));

	// one row read port: scan track on ticks, addressed cell otherwise
	assign is_tick  = (op_q == dss_pkg::OP_TICK);
	assign row_addr = is_tick ? trk_q : t_q[TRK_W-1:0];
	assign col_addr = is_tick ? pos_q : s_q[POS_W-1:0];
	assign row      = grid_q[row_addr];
	assign cell_bit = row[col_addr];

	assign trk_ext = {4'b0000, trk_q};
	assign pos_ext = {4'b0000, pos_q};

	// jump condition select
	always_comb begin
		case (cw.cond)
			dss_pkg::CND_NEVER:   jump = 1'b0;
			dss_pkg::CND_ALWAYS:  jump = 1'b1;
			dss_pkg::CND_NOSTART: jump = !start;
			dss_pkg::CND_CELLOP:  jump = !is_tick;
			dss_pkg::CND_RESTART: jump = rst_q;
			dss_pkg::CND_STOPPED: jump = !run_q;
			dss_pkg::CND_SUMLOW:  jump = (sum_q < dss_pkg::SUM_W'(dss_pkg::UNITS_PER_STEP));
			dss_pkg::CND_TRKMORE: jump = (trk_q != TRK_W'(TRACK_COUNT - 1));
			default:              jump = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dss_pkg::STP_IDLE;
		end else if (jump) begin
			step_q <= cw.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

	// configuration registers, tempo clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tempo_q <= dss_pkg::TEMPO_RESET;
			run_q   <= 1'b0;
		end else if (cfg_write) begin
			if (cfg_index == dss_pkg::REG_TEMPO) begin
				if (cfg_data < dss_pkg::TEMPO_MIN) begin
					tempo_q <= dss_pkg::TEMPO_MIN;
				end else if (cfg_data > dss_pkg::TEMPO_MAX) begin
					tempo_q <= dss_pkg::TEMPO_MAX;
				end else begin
					tempo_q <= cfg_data;
				end
			end else begin
				run_q <= cfg_data[0];
			end
		end
	end

	// item capture and working registers (payload, no reset)
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			rst_q   <= restart;
			us_q    <= elapsed_us;
			t_q     <= track_index;
			s_q     <= step_index;
			en_q    <= cell_enable;
			readv_q <= 1'b0;
		end
		case (cw.act)
			dss_pkg::ACT_MUL:     prod_q <= 24'(us_q) * 24'(tempo_q);
			dss_pkg::ACT_ADD:     sum_q  <= {1'b0, acc_q} + {1'b0, prod_q};
			dss_pkg::ACT_ADVANCE: begin
				if (!jump) begin
					sum_q <= sum_q - dss_pkg::SUM_W'(dss_pkg::UNITS_PER_STEP);
					trk_q <= '0;
				end
			end
			dss_pkg::ACT_SCAN:    trk_q <= trk_q + 1'b1;
			dss_pkg::ACT_CELL:    readv_q <= in_range && (op_q == dss_pkg::OP_READ) && cell_bit;
			default: ;
		endcase
	end

	// sequence state and grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			acc_q   <= '0;
			ntrig_q <= '0;
			for (int i = 0; i < TRACK_COUNT; i++) begin
				grid_q[i] <= '0;
			end
		end else begin
			if (accept) begin
				ntrig_q <= '0;
			end
			case (cw.act)
				dss_pkg::ACT_ADVANCE: begin
					if (!jump) begin
						if (pos_q == POS_W'(STEP_COUNT - 1)) begin
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + 1'b1;
						end
					end
				end
				dss_pkg::ACT_SCAN: begin
					if (cell_bit && !ntrig_q[4]) begin
						ntrig_q <= ntrig_q + 1'b1;
					end
				end
				dss_pkg::ACT_COMMIT: acc_q <= sum_q[dss_pkg::ACC_W-1:0];
				dss_pkg::ACT_CLEAR: begin
					pos_q <= '0;
					acc_q <= '0;
				end
				dss_pkg::ACT_CELL: begin
					if (in_range) begin
						if (op_q == dss_pkg::OP_WRITE) begin
							grid_q[row_addr][col_addr] <= en_q;
						end else if (op_q == dss_pkg::OP_TOGGLE) begin
							grid_q[row_addr][col_addr] <= !cell_bit;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= ((cw.act == dss_pkg::ACT_SCAN) && cell_bit && !ntrig_q[4])
				|| (step_q == dss_pkg::STP_CLOSE);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (step_q == dss_pkg::STP_CLOSE) begin
			kind        <= 1'b1;
			fired_track <= 4'd0;
			position    <= pos_ext[3:0];
			cell_value  <= readv_q;
			last        <= 1'b1;
		end else if (cw.act == dss_pkg::ACT_SCAN) begin
			kind        <= 1'b0;
			fired_track <= trk_ext[3:0];
			position    <= pos_ext[3:0];
			cell_value  <= 1'b0;
			last        <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_close_from_program: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> ($past(step_q) == dss_pkg::STP_CLOSE))
		else $error("closing item not issued by close step");

	a_busy_ends_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (strobe && last))
		else $error("busy dropped without closing item");

	a_trigger_cap: assert property (@(posedge clk) disable iff (!arst_n)
		ntrig_q <= 5'(dss_pkg::TRIG_LIMIT))
		else $error("trigger count beyond limit");

	a_acc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_q < dss_pkg::ACC_W'(dss_pkg::UNITS_PER_STEP))
		else $error("accumulator not reduced below one step");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (step_q == dss_pkg::STP_DISP))
		else $error("accepted item not dispatched");

endmodule
